FILE: rtl/dfs_pkg.sv
// ----------------------------------------------------------------------------
// Depth-first traversal package
// Shared sizes, codes and structs of the depth-first traversal block.
// ----------------------------------------------------------------------------
package dfs_pkg;

    // Capacity of the adjacency store
    localparam int MAX_VERTICES = 32;
    localparam int MAX_ARCS     = 1024;

    // Derived internal widths
    localparam int VIDX_W = $clog2(MAX_VERTICES);
    localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
    localparam int AIDX_W = $clog2(MAX_ARCS);
    localparam int ACNT_W = $clog2(MAX_ARCS + 1);
    localparam int LIM_W  = 2 * VCNT_W;
    localparam int CMP_W  = (LIM_W > ACNT_W) ? LIM_W : ACNT_W;

    // Fixed field widths of the channels
    localparam int ACTION_W = 2;
    localparam int SYMBOL_W = 8;
    localparam int TARGET_W = 5;
    localparam int VERTEX_W = 5;
    localparam int COUNT_W  = 6;
    localparam int KIND_W   = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD_VERTEX = 2'd0,
        ACT_ADD_ARC    = 2'd1,
        ACT_START      = 2'd2,
        ACT_CLEAR      = 2'd3
    } t_action;

    typedef enum logic [KIND_W-1:0] {
        KIND_DIR_GRAPH   = 2'd0,
        KIND_DIR_NET     = 2'd1,
        KIND_UNDIR_GRAPH = 2'd2,
        KIND_UNDIR_NET   = 2'd3
    } t_kind;

    // One result item
    typedef struct packed {
        logic                is_visit;
        logic [VERTEX_W-1:0] vertex_index;
        logic [SYMBOL_W-1:0] symbol_out;
        logic                tree_root;
        logic [COUNT_W-1:0]  tree_count;
        logic                count_error;
        logic                last;
    } t_result;

    // Walk stack command and status
    typedef struct packed {
        logic              clear;
        logic              push;
        logic              pop;
        logic              upd;
        logic [VIDX_W-1:0] vtx;
        logic [ACNT_W-1:0] ptr;
    } t_stk_cmd;

    typedef struct packed {
        logic              empty;
        logic [VIDX_W-1:0] top_vtx;
        logic [ACNT_W-1:0] top_ptr;
    } t_stk_stat;

    // Memory port requests
    typedef struct packed {
        logic                we;
        logic [VIDX_W-1:0]   waddr;
        logic [SYMBOL_W-1:0] wdata;
        logic                re;
        logic [VIDX_W-1:0]   raddr;
    } t_sym_req;

    typedef struct packed {
        logic              we;
        logic [VIDX_W-1:0] waddr;
        logic [ACNT_W-1:0] wdata;
        logic              re;
        logic [VIDX_W-1:0] raddr;
    } t_end_req;

    typedef struct packed {
        logic                we;
        logic [AIDX_W-1:0]   waddr;
        logic [TARGET_W-1:0] wdata;
        logic                re;
        logic [AIDX_W-1:0]   raddr;
    } t_arc_req;

endpackage

FILE: rtl/dfs_if.sv
// ----------------------------------------------------------------------------
// Depth-first traversal channels
// Valid/ready channel interfaces for configuration, load items and results.
// ----------------------------------------------------------------------------

// Configuration write channel
interface dfs_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [dfs_pkg::KIND_W-1:0]   graph_kind;

    modport source (output valid, output graph_kind, input ready);
    modport sink   (input valid, input graph_kind, output ready);
endinterface

// Load and start item channel
interface dfs_in_if;
    logic                         valid;
    logic                         ready;
    logic [dfs_pkg::ACTION_W-1:0] action;
    logic [dfs_pkg::SYMBOL_W-1:0] vertex_symbol;
    logic [dfs_pkg::TARGET_W-1:0] arc_target;

    modport source (output valid, output action, output vertex_symbol,
                    output arc_target, input ready);
    modport sink   (input valid, input action, input vertex_symbol,
                    input arc_target, output ready);
endinterface

// Result item channel
interface dfs_out_if;
    logic                         valid;
    logic                         ready;
    logic                         is_visit;
    logic [dfs_pkg::VERTEX_W-1:0] vertex_index;
    logic [dfs_pkg::SYMBOL_W-1:0] symbol_out;
    logic                         tree_root;
    logic [dfs_pkg::COUNT_W-1:0]  tree_count;
    logic                         count_error;
    logic                         last;

    modport source (output valid, output is_visit, output vertex_index,
                    output symbol_out, output tree_root, output tree_count,
                    output count_error, output last, input ready);
    modport sink   (input valid, input is_visit, input vertex_index,
                    input symbol_out, input tree_root, input tree_count,
                    input count_error, input last, output ready);
endinterface

FILE: rtl/dfs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/dfs_stack.sv
// ----------------------------------------------------------------------------
// Walk stack
// Holds the open vertices of the walk with the next arc pointer of each.
// ----------------------------------------------------------------------------
module dfs_stack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dfs_pkg::t_stk_cmd  i_cmd,
    output dfs_pkg::t_stk_stat o_stat
);

    localparam int DEPTH = dfs_pkg::MAX_VERTICES;
    localparam int VW    = dfs_pkg::VIDX_W;
    localparam int DW    = dfs_pkg::VCNT_W;
    localparam int PW    = dfs_pkg::ACNT_W;

    logic [VW-1:0] r_vtx [DEPTH];
    logic [PW-1:0] r_ptr [DEPTH];
    logic [DW-1:0] r_depth;
    logic [DW-1:0] top_pos;
    logic [VW-1:0] top_idx;
    logic [VW-1:0] push_idx;

    assign top_pos  = r_depth - 1'b1;
    assign top_idx  = top_pos[VW-1:0];
    assign push_idx = r_depth[VW-1:0];

    // Depth counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_cmd.clear) begin
            r_depth <= '0;
        end else if (i_cmd.push) begin
            r_depth <= r_depth + 1'b1;
        end else if (i_cmd.pop) begin
            r_depth <= top_pos;
        end
    end

    // Entries: push writes a new top, update advances the top's arc pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_vtx[push_idx] <= i_cmd.vtx;
            r_ptr[push_idx] <= i_cmd.ptr;
        end else if (i_cmd.upd) begin
            r_ptr[top_idx] <= i_cmd.ptr;
        end
    end

    assign o_stat.empty   = (r_depth == '0);
    assign o_stat.top_vtx = r_vtx[top_idx];
    assign o_stat.top_ptr = r_ptr[top_idx];

    // Each vertex enters at most once per walk, so the stack never fills.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (32'(r_depth) < DEPTH))
        else $error("walk stack push while full");

    // The sequencer only pops or advances an entry that exists.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pop || i_cmd.upd) |-> (r_depth != '0))
        else $error("walk stack pop or update while empty");

    // One stack operation per cycle.
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clear, i_cmd.push, i_cmd.pop, i_cmd.upd}))
        else $error("walk stack got several operations at once");

endmodule

FILE: rtl/dfs_seq.sv
// ----------------------------------------------------------------------------
// Traversal sequencer
// Loads the adjacency store and steps the depth-first walk arc by arc.
// ----------------------------------------------------------------------------
module dfs_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dfs_cfg_if.sink            i_cfg,
    dfs_in_if.sink             i_in,
    dfs_out_if.source          o_out,
    output dfs_pkg::t_stk_cmd  o_stk_cmd,
    input  dfs_pkg::t_stk_stat i_stk_stat,
    output dfs_pkg::t_sym_req  o_sym_req,
    input  logic [dfs_pkg::SYMBOL_W-1:0] i_sym_rdata,
    output dfs_pkg::t_end_req  o_end_req,
    input  logic [dfs_pkg::ACNT_W-1:0]   i_end_rdata,
    output dfs_pkg::t_arc_req  o_arc_req,
    input  logic [dfs_pkg::TARGET_W-1:0] i_arc_rdata
);

    localparam int NV  = dfs_pkg::MAX_VERTICES;
    localparam int VW  = dfs_pkg::VIDX_W;
    localparam int VCW = dfs_pkg::VCNT_W;
    localparam int AW  = dfs_pkg::AIDX_W;
    localparam int ACW = dfs_pkg::ACNT_W;
    localparam int LW  = dfs_pkg::LIM_W;
    localparam int CPW = dfs_pkg::CMP_W;
    localparam int OVW = dfs_pkg::VERTEX_W;
    localparam int OCW = dfs_pkg::COUNT_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LIMIT = 8'b0000_0010,
        S_CHECK = 8'b0000_0100,
        S_ROOT  = 8'b0000_1000,
        S_VIS   = 8'b0001_0000,
        S_TOP   = 8'b0010_0000,
        S_ARC   = 8'b0100_0000,
        S_FINAL = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    dfs_pkg::t_kind    r_kind;
    logic [VCW-1:0]    r_vtot, n_vtot;
    logic [ACW-1:0]    r_atot, n_atot;
    logic              r_ovf, n_ovf;
    logic [NV-1:0]     r_visited, n_visited;
    logic [VCW-1:0]    r_trees, n_trees;
    logic [VCW-1:0]    r_root, n_root;
    logic [VW-1:0]     r_v, n_v;
    logic              r_is_root, n_is_root;
    logic [LW-1:0]     r_lim, n_lim;
    logic              r_lim_err, n_lim_err;
    dfs_pkg::t_result  r_out, n_out;
    logic              r_out_valid;
    logic              out_load;
    logic              out_free;

    logic [VCW-1:0]    vlast;
    logic [ACW-1:0]    atot_inc;
    logic [LW-1:0]     prod;
    logic [VW-1:0]     root_idx;
    logic [VW-1:0]     w_idx;
    logic [ACW-1:0]    arc_ptr;
    logic [VW-1:0]     vis_begin_addr;
    logic              undirected;
    dfs_pkg::t_action  act;

    assign vlast      = r_vtot - 1'b1;
    assign atot_inc   = r_atot + 1'b1;
    assign prod       = LW'(r_vtot) * LW'(vlast);
    assign root_idx   = r_root[VW-1:0];
    assign w_idx      = VW'(i_arc_rdata);
    assign arc_ptr    = i_stk_stat.top_ptr;
    assign undirected = (r_kind == dfs_pkg::KIND_UNDIR_GRAPH) ||
                        (r_kind == dfs_pkg::KIND_UNDIR_NET);
    assign act        = dfs_pkg::t_action'(i_in.action);
    assign out_free   = !r_out_valid || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // Sequencer next state, store writes and memory reads
    always_comb begin
        n_state   = r_state;
        n_vtot    = r_vtot;
        n_atot    = r_atot;
        n_ovf     = r_ovf;
        n_visited = r_visited;
        n_trees   = r_trees;
        n_root    = r_root;
        n_v       = r_v;
        n_is_root = r_is_root;
        n_lim     = r_lim;
        n_lim_err = r_lim_err;
        n_out     = r_out;
        out_load  = 1'b0;
        vis_begin_addr = '0;
        o_stk_cmd = '0;
        o_sym_req = '0;
        o_end_req = '0;
        o_arc_req = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    unique case (act)
                        dfs_pkg::ACT_ADD_VERTEX: begin
                            if (32'(r_vtot) < NV) begin
                                o_sym_req.we    = 1'b1;
                                o_sym_req.waddr = r_vtot[VW-1:0];
                                o_sym_req.wdata = i_in.vertex_symbol;
                                o_end_req.we    = 1'b1;
                                o_end_req.waddr = r_vtot[VW-1:0];
                                o_end_req.wdata = r_atot;
                                n_vtot          = r_vtot + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        dfs_pkg::ACT_ADD_ARC: begin
                            if (r_vtot != '0) begin
                                if (32'(r_atot) < dfs_pkg::MAX_ARCS) begin
                                    o_arc_req.we    = 1'b1;
                                    o_arc_req.waddr = r_atot[AW-1:0];
                                    o_arc_req.wdata = i_in.arc_target;
                                    o_end_req.we    = 1'b1;
                                    o_end_req.waddr = vlast[VW-1:0];
                                    o_end_req.wdata = atot_inc;
                                    n_atot          = atot_inc;
                                end else begin
                                    n_ovf = 1'b1;
                                end
                            end
                        end
                        dfs_pkg::ACT_START: begin
                            n_state = S_LIMIT;
                        end
                        dfs_pkg::ACT_CLEAR: begin
                            n_vtot = '0;
                            n_atot = '0;
                            n_ovf  = 1'b0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // Arc limit n*(n-1), halved for the undirected kinds
            S_LIMIT: begin
                if (r_vtot == '0) begin
                    n_lim = '0;
                end else if (undirected) begin
                    n_lim = prod >> 1;
                end else begin
                    n_lim = prod;
                end
                n_state = S_CHECK;
            end

            S_CHECK: begin
                if (CPW'(r_atot) > CPW'(r_lim)) begin
                    n_lim_err = 1'b1;
                    n_state   = S_FINAL;
                end else begin
                    n_lim_err       = 1'b0;
                    n_visited       = '0;
                    n_trees         = '0;
                    n_root          = '0;
                    o_stk_cmd.clear = 1'b1;
                    n_state         = S_ROOT;
                end
            end

            // Scan for the next unvisited root in index order
            S_ROOT: begin
                if (r_root == r_vtot) begin
                    n_state = S_FINAL;
                end else if (r_visited[root_idx]) begin
                    n_root = r_root + 1'b1;
                end else begin
                    n_trees         = r_trees + 1'b1;
                    n_v             = root_idx;
                    n_is_root       = 1'b1;
                    vis_begin_addr  = root_idx - 1'b1;
                    o_sym_req.re    = 1'b1;
                    o_sym_req.raddr = root_idx;
                    o_end_req.re    = 1'b1;
                    o_end_req.raddr = vis_begin_addr;
                    n_state         = S_VIS;
                end
            end

            // Report the vertex and push it with its first arc
            S_VIS: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    n_out              = '0;
                    n_out.is_visit     = 1'b1;
                    n_out.vertex_index = OVW'(r_v);
                    n_out.symbol_out   = i_sym_rdata;
                    n_out.tree_root    = r_is_root;
                    n_visited[r_v]     = 1'b1;
                    o_stk_cmd.push     = 1'b1;
                    o_stk_cmd.vtx      = r_v;
                    o_stk_cmd.ptr      = (r_v == '0) ? '0 : i_end_rdata;
                    n_state            = S_TOP;
                end
            end

            // Fetch the top vertex's arc end and the next arc target
            S_TOP: begin
                if (i_stk_stat.empty) begin
                    n_state = S_ROOT;
                end else begin
                    o_end_req.re    = 1'b1;
                    o_end_req.raddr = i_stk_stat.top_vtx;
                    o_arc_req.re    = 1'b1;
                    o_arc_req.raddr = arc_ptr[AW-1:0];
                    n_state         = S_ARC;
                end
            end

            // Follow one arc, or retire the top vertex when its arcs are done
            S_ARC: begin
                if ((arc_ptr >= i_end_rdata) || (32'(arc_ptr) >= dfs_pkg::MAX_ARCS)) begin
                    o_stk_cmd.pop = 1'b1;
                    n_state       = S_TOP;
                end else begin
                    o_stk_cmd.upd = 1'b1;
                    o_stk_cmd.ptr = arc_ptr + 1'b1;
                    if ((32'(i_arc_rdata) < 32'(r_vtot)) && !r_visited[w_idx]) begin
                        n_v             = w_idx;
                        n_is_root       = 1'b0;
                        vis_begin_addr  = w_idx - 1'b1;
                        o_sym_req.re    = 1'b1;
                        o_sym_req.raddr = w_idx;
                        o_end_req.re    = 1'b1;
                        o_end_req.raddr = vis_begin_addr;
                        n_state         = S_VIS;
                    end else begin
                        n_state = S_TOP;
                    end
                end
            end

            // Closing item: tree count with the load overflow flag, or the arc limit error
            S_FINAL: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    n_out             = '0;
                    n_out.tree_count  = r_lim_err ? '0 : OCW'(r_trees);
                    n_out.count_error = r_lim_err | r_ovf;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= dfs_pkg::KIND_UNDIR_GRAPH;
            r_vtot      <= '0;
            r_atot      <= '0;
            r_ovf       <= 1'b0;
            r_visited   <= '0;
            r_trees     <= '0;
            r_root      <= '0;
            r_lim_err   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_vtot    <= n_vtot;
            r_atot    <= n_atot;
            r_ovf     <= n_ovf;
            r_visited <= n_visited;
            r_trees   <= n_trees;
            r_root    <= n_root;
            r_lim_err <= n_lim_err;
            if (i_cfg.valid) begin
                r_kind <= dfs_pkg::t_kind'(i_cfg.graph_kind);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_v       <= n_v;
        r_is_root <= n_is_root;
        r_lim     <= n_lim;
        r_out     <= n_out;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.is_visit     = r_out.is_visit;
    assign o_out.vertex_index = r_out.vertex_index;
    assign o_out.symbol_out   = r_out.symbol_out;
    assign o_out.tree_root    = r_out.tree_root;
    assign o_out.tree_count   = r_out.tree_count;
    assign o_out.count_error  = r_out.count_error;
    assign o_out.last         = r_out.last;

    // An arc is only examined while some vertex is open.
    a_arc_has_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ARC) |-> !i_stk_stat.empty)
        else $error("arc step with an empty walk stack");

    // No vertex is reported twice in one walk.
    a_visit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VIS) |-> !r_visited[r_v])
        else $error("vertex visited a second time");

    // The root scan never runs past the loaded vertices.
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> (r_root <= r_vtot))
        else $error("root scan beyond the vertex total");

endmodule

FILE: rtl/dfs_forest_traversal_top.sv
// ----------------------------------------------------------------------------
// Depth-first forest traversal
// Adjacency store loader and depth-first walk with a count of its trees.
// ----------------------------------------------------------------------------
// Load items (add vertex, add arc, clear) are taken one per cycle and give no
// result. A start item runs the whole walk before the next item is taken:
// a step to compute the arc limit of the graph kind and one to check the arc
// total against it, a root scan step per vertex plus one more per tree and
// one to end the scan, a step per visited vertex to report and push it (its
// symbol and arc-start read are issued in the step that found it), a fetch
// step (arc memory and end-pointer read) and a decision step per stored arc or
// retired vertex, a step per tree when its stack runs empty, and a step for the
// closing item. The visit and closing steps wait while the result side stalls;
// a start that fails the arc limit goes straight to the closing item. The
// single-read-port arc memory and end-pointer memory split each arc into the
// fetch and decision steps. The stores hold no reset contents; vertex and arc
// counts bound every read whose data is used.
module dfs_forest_traversal_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dfs_cfg_if.sink   i_cfg,
    dfs_in_if.sink    i_in,
    dfs_out_if.source o_out
);

    dfs_pkg::t_stk_cmd  stk_cmd;
    dfs_pkg::t_stk_stat stk_stat;
    dfs_pkg::t_sym_req  sym_req;
    dfs_pkg::t_end_req  end_req;
    dfs_pkg::t_arc_req  arc_req;
    logic [dfs_pkg::SYMBOL_W-1:0] sym_rdata;
    logic [dfs_pkg::ACNT_W-1:0]   end_rdata;
    logic [dfs_pkg::TARGET_W-1:0] arc_rdata;

    // Vertex symbols
    dfs_ram #(
        .WIDTH (dfs_pkg::SYMBOL_W),
        .DEPTH (dfs_pkg::MAX_VERTICES)
    ) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (sym_req.we),
        .i_waddr (sym_req.waddr),
        .i_wdata (sym_req.wdata),
        .i_re    (sym_req.re),
        .i_raddr (sym_req.raddr),
        .o_rdata (sym_rdata)
    );

    // Arc end pointer of each vertex
    dfs_ram #(
        .WIDTH (dfs_pkg::ACNT_W),
        .DEPTH (dfs_pkg::MAX_VERTICES)
    ) u_end_ram (
        .i_clk   (i_clk),
        .i_we    (end_req.we),
        .i_waddr (end_req.waddr),
        .i_wdata (end_req.wdata),
        .i_re    (end_req.re),
        .i_raddr (end_req.raddr),
        .o_rdata (end_rdata)
    );

    // Arc targets in arrival order
    dfs_ram #(
        .WIDTH (dfs_pkg::TARGET_W),
        .DEPTH (dfs_pkg::MAX_ARCS)
    ) u_arc_ram (
        .i_clk   (i_clk),
        .i_we    (arc_req.we),
        .i_waddr (arc_req.waddr),
        .i_wdata (arc_req.wdata),
        .i_re    (arc_req.re),
        .i_raddr (arc_req.raddr),
        .o_rdata (arc_rdata)
    );

    // Open vertices of the walk
    dfs_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_stat  (stk_stat)
    );

    // Loader and walk sequencer
    dfs_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_stk_cmd   (stk_cmd),
        .i_stk_stat  (stk_stat),
        .o_sym_req   (sym_req),
        .i_sym_rdata (sym_rdata),
        .o_end_req   (end_req),
        .i_end_rdata (end_rdata),
        .o_arc_req   (arc_req),
        .i_arc_rdata (arc_rdata)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-first forest traversal testbench
// Builds hand-made and random graphs under every graph kind, starts walks
// with random gaps on both channels, and checks each report item against a
// preorder walk predicted from the loads that the block has accepted.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 32;
    localparam int RANDOM_ITEMS   = 400;

    // One load or start item as it waits for the driver
    typedef struct packed {
        dfs_pkg::t_action             act;
        logic [dfs_pkg::SYMBOL_W-1:0] sym;
        logic [dfs_pkg::TARGET_W-1:0] tgt;
    } t_load_item;

    logic i_clk;
    logic rst_n;

    dfs_cfg_if cfg_ch ();
    dfs_in_if  in_ch ();
    dfs_out_if out_ch ();

    dfs_forest_traversal_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predicted graph store and register copy
    logic [dfs_pkg::SYMBOL_W-1:0] sym_mem [dfs_pkg::MAX_VERTICES];
    logic [dfs_pkg::TARGET_W-1:0] tgt_mem [dfs_pkg::MAX_ARCS];
    int                           arc_end [dfs_pkg::MAX_VERTICES];
    int                           vtx_cnt;
    int                           arc_cnt;
    bit                           load_dropped;
    dfs_pkg::t_kind               kind_now;

    dfs_pkg::t_result             pending_reports [$];
    t_load_item                   load_q [$];

    int gap_pct;
    int stall_pct;
    int fail_cnt;
    int quiet_cycles;
    int items_queued;
    bit in_taken;

    // Graph size as the stimulus generator sees it
    int gen_vtx;
    int gen_arc;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic string show_report(dfs_pkg::t_result r);
        return $sformatf("visit=%0b vertex=%0d symbol=%02h root=%0b trees=%0d error=%0b last=%0b",
                         r.is_visit, r.vertex_index, r.symbol_out, r.tree_root,
                         r.tree_count, r.count_error, r.last);
    endfunction

    // Predict the reports of one start: either the single limit error, or a
    // preorder walk from each unvisited vertex followed by the tree count.
    function automatic void predict_walk();
        dfs_pkg::t_result rep;
        int      lim;
        int      trees;
        int      depth;
        int      r;
        int      nxt;
        int      v;
        int      p;
        int      w;
        bit      is_root;
        int      stk_v [dfs_pkg::MAX_VERTICES];
        int      stk_p [dfs_pkg::MAX_VERTICES];
        bit      seen [dfs_pkg::MAX_VERTICES];
        lim = (vtx_cnt == 0) ? 0 : vtx_cnt * (vtx_cnt - 1);
        if (kind_now == dfs_pkg::KIND_UNDIR_GRAPH || kind_now == dfs_pkg::KIND_UNDIR_NET) begin
            lim = lim / 2;
        end
        rep = '0;
        if (arc_cnt > lim) begin
            rep.count_error = 1'b1;
            rep.last        = 1'b1;
            pending_reports.push_back(rep);
            return;
        end
        foreach (seen[i]) seen[i] = 1'b0;
        trees = 0;
        depth = 0;
        for (r = 0; r < vtx_cnt; r++) begin
            if (!seen[r]) begin
                trees++;
                nxt     = r;
                is_root = 1'b1;
                while (nxt >= 0 || depth > 0) begin
                    if (nxt >= 0) begin
                        // Report the vertex and push it with its first arc.
                        seen[nxt]        = 1'b1;
                        rep              = '0;
                        rep.is_visit     = 1'b1;
                        rep.vertex_index = nxt[dfs_pkg::VERTEX_W-1:0];
                        rep.symbol_out   = sym_mem[nxt];
                        rep.tree_root    = is_root;
                        pending_reports.push_back(rep);
                        stk_v[depth] = nxt;
                        stk_p[depth] = (nxt == 0) ? 0 : arc_end[nxt - 1];
                        depth++;
                        nxt     = -1;
                        is_root = 1'b0;
                    end else begin
                        v = stk_v[depth - 1];
                        p = stk_p[depth - 1];
                        if (p >= arc_end[v]) begin
                            depth--;
                        end else begin
                            stk_p[depth - 1] = p + 1;
                            w = int'(tgt_mem[p]);
                            if (w < vtx_cnt && !seen[w]) begin
                                nxt = w;
                            end
                        end
                    end
                end
            end
        end
        rep             = '0;
        rep.tree_count  = trees[dfs_pkg::COUNT_W-1:0];
        rep.count_error = load_dropped;
        rep.last        = 1'b1;
        pending_reports.push_back(rep);
    endfunction

    // Update the predicted store with one accepted item.
    function automatic void apply_load_item(t_load_item it);
        case (it.act)
            dfs_pkg::ACT_ADD_VERTEX: begin
                if (vtx_cnt < dfs_pkg::MAX_VERTICES) begin
                    sym_mem[vtx_cnt] = it.sym;
                    arc_end[vtx_cnt] = arc_cnt;
                    vtx_cnt++;
                end else begin
                    load_dropped = 1'b1;
                end
            end
            dfs_pkg::ACT_ADD_ARC: begin
                // An arc with no vertex to hang on is ignored.
                if (vtx_cnt != 0) begin
                    if (arc_cnt < dfs_pkg::MAX_ARCS) begin
                        tgt_mem[arc_cnt] = it.tgt;
                        arc_cnt++;
                        arc_end[vtx_cnt - 1] = arc_cnt;
                    end else begin
                        load_dropped = 1'b1;
                    end
                end
            end
            dfs_pkg::ACT_START: begin
                predict_walk();
            end
            default: begin
                vtx_cnt      = 0;
                arc_cnt      = 0;
                load_dropped = 1'b0;
            end
        endcase
    endfunction

    function automatic void queue_item(dfs_pkg::t_action act, int sym, int tgt);
        t_load_item it;
        it.act = act;
        it.sym = sym[dfs_pkg::SYMBOL_W-1:0];
        it.tgt = tgt[dfs_pkg::TARGET_W-1:0];
        load_q.push_back(it);
        items_queued++;
    endfunction

    // Queue one random graph and a start. Most graphs stay within the arc
    // limit of the kind so that the walk runs; a few are pushed past it.
    function automatic void queue_graph(bit directed);
        int n;
        int total;
        int room;
        int k;
        int i;
        int noise;
        bit overfill;
        if (gen_vtx > 16 || $urandom_range(99) < 80) begin
            queue_item(dfs_pkg::ACT_CLEAR, $urandom_range(255), $urandom_range(31));
            gen_vtx = 0;
            gen_arc = 0;
        end
        // A stray arc: ignored on an empty graph, else added to the newest vertex.
        if ($urandom_range(9) == 0) begin
            queue_item(dfs_pkg::ACT_ADD_ARC, $urandom_range(255), $urandom_range(31));
            if (gen_vtx != 0) begin
                gen_arc++;
            end
        end
        overfill = ($urandom_range(9) == 0);
        if (overfill) begin
            n = $urandom_range(3, 1);
        end else if ($urandom_range(14) == 0) begin
            n = 0;
        end else begin
            n = $urandom_range(10, 1);
        end
        total = gen_vtx + n;
        room  = (total == 0) ? 0 : total * (total - 1);
        if (!directed) begin
            room = room / 2;
        end
        room = room - gen_arc;
        for (i = 0; i < n; i++) begin
            queue_item(dfs_pkg::ACT_ADD_VERTEX, $urandom_range(255), $urandom_range(31));
            gen_vtx++;
            k = $urandom_range(4);
            while (k > 0 && room > 0) begin
                queue_item(dfs_pkg::ACT_ADD_ARC, $urandom_range(255),
                           ($urandom_range(9) == 0) ? $urandom_range(31)
                                                    : $urandom_range(total - 1));
                k--;
                room--;
                gen_arc++;
            end
        end
        if (overfill && gen_vtx > 0) begin
            while (room >= 0) begin
                queue_item(dfs_pkg::ACT_ADD_ARC, $urandom_range(255),
                           $urandom_range(total - 1));
                room--;
                gen_arc++;
            end
        end
        queue_item(dfs_pkg::ACT_START, $urandom_range(255), $urandom_range(31));
        // Now and then some random items; the next graph then starts afresh.
        if ($urandom_range(7) == 0) begin
            noise = $urandom_range(3, 1);
            for (i = 0; i < noise; i++) begin
                queue_item(dfs_pkg::t_action'($urandom_range(3)), $urandom_range(255),
                           $urandom_range(31));
            end
            gen_vtx = dfs_pkg::MAX_VERTICES;
        end
    endfunction

    // Write the graph kind register; called only while the block is idle.
    task automatic write_kind(dfs_pkg::t_kind k);
        @(negedge i_clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.graph_kind <= k;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait until every queued item is taken and every report has arrived.
    task automatic wait_idle();
        while (load_q.size() != 0 || in_ch.valid || pending_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_phase(dfs_pkg::t_kind k, int cnt);
        int stop_at;
        write_kind(k);
        stop_at = items_queued + cnt;
        while (items_queued < stop_at) begin
            queue_graph(k == dfs_pkg::KIND_DIR_GRAPH || k == dfs_pkg::KIND_DIR_NET);
        end
        wait_idle();
    endtask

    // Load item driver and result ready, both changed at the falling edge
    always @(negedge i_clk) begin : load_driver
        t_load_item nxt;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (load_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                nxt = load_q.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.action        <= nxt.act;
                in_ch.vertex_symbol <= nxt.sym;
                in_ch.arc_target    <= nxt.tgt;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    // Monitor: track accepted items, check reports, and guard against a hang
    always @(posedge i_clk) begin : report_monitor
        t_load_item       it;
        dfs_pkg::t_result got;
        dfs_pkg::t_result want;
        if (!rst_n) begin
            in_taken     <= 1'b0;
            quiet_cycles = 0;
        end else begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (cfg_ch.valid && cfg_ch.ready) begin
                kind_now = dfs_pkg::t_kind'(cfg_ch.graph_kind);
            end
            if (in_ch.valid && in_ch.ready) begin
                it.act = dfs_pkg::t_action'(in_ch.action);
                it.sym = in_ch.vertex_symbol;
                it.tgt = in_ch.arc_target;
                apply_load_item(it);
            end
            if (out_ch.valid && out_ch.ready) begin
                got.is_visit     = out_ch.is_visit;
                got.vertex_index = out_ch.vertex_index;
                got.symbol_out   = out_ch.symbol_out;
                got.tree_root    = out_ch.tree_root;
                got.tree_count   = out_ch.tree_count;
                got.count_error  = out_ch.count_error;
                got.last         = out_ch.last;
                if (pending_reports.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected report, expected none, got %s",
                             $time, show_report(got));
                end else begin
                    want = pending_reports.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        $display("%0t: report mismatch, expected %s, got %s",
                                 $time, show_report(want), show_report(got));
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("dfs_forest_traversal_top: mismatch");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial begin : stimulus
        int i;
        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.graph_kind   = dfs_pkg::KIND_UNDIR_GRAPH;
        vtx_cnt             = 0;
        arc_cnt             = 0;
        load_dropped        = 1'b0;
        kind_now            = dfs_pkg::KIND_UNDIR_GRAPH;
        gap_pct             = 37;
        stall_pct           = 37;
        fail_cnt            = 0;
        items_queued        = 0;
        gen_vtx             = dfs_pkg::MAX_VERTICES;
        gen_arc             = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Hand-built cases under the reset graph kind (undirected graph).
        // Start on an empty graph, then an arc with no vertex yet.
        queue_item(dfs_pkg::ACT_START, 0, 0);
        queue_item(dfs_pkg::ACT_ADD_ARC, 0, 3);
        // Five vertices with symbol extremes; arcs to a later vertex, to the
        // highest unloaded index and back to visited vertices.
        queue_item(dfs_pkg::ACT_ADD_VERTEX, 8'h00, 0);
        queue_item(dfs_pkg::ACT_ADD_ARC, 0, 2);
        queue_item(dfs_pkg::ACT_ADD_ARC, 0, 31);
        queue_item(dfs_pkg::ACT_ADD_VERTEX, 8'hFF, 0);
        queue_item(dfs_pkg::ACT_ADD_ARC, 0, 0);
        queue_item(dfs_pkg::ACT_ADD_VERTEX, 8'hA5, 0);
        queue_item(dfs_pkg::ACT_ADD_ARC, 0, 1);
        queue_item(dfs_pkg::ACT_ADD_ARC, 0, 3);
        queue_item(dfs_pkg::ACT_ADD_VERTEX, 8'h5A, 0);
        queue_item(dfs_pkg::ACT_ADD_VERTEX, 8'h3C, 31);
        queue_item(dfs_pkg::ACT_ADD_ARC, 8'hFF, 3);
        queue_item(dfs_pkg::ACT_START, 0, 0);
        // Clear, then start on the emptied graph.
        queue_item(dfs_pkg::ACT_CLEAR, 0, 0);
        queue_item(dfs_pkg::ACT_START, 0, 0);
        // Two vertices with two arcs exceed the undirected limit of one.
        queue_item(dfs_pkg::ACT_ADD_VERTEX, 8'h81, 0);
        queue_item(dfs_pkg::ACT_ADD_VERTEX, 8'h7E, 0);
        queue_item(dfs_pkg::ACT_ADD_ARC, 0, 0);
        queue_item(dfs_pkg::ACT_ADD_ARC, 0, 1);
        queue_item(dfs_pkg::ACT_START, 0, 0);
        wait_idle();

        // Capacity: one vertex too many, then a clear.
        write_kind(dfs_pkg::KIND_DIR_GRAPH);
        queue_item(dfs_pkg::ACT_CLEAR, 0, 0);
        for (i = 0; i <= dfs_pkg::MAX_VERTICES; i++) begin
            queue_item(dfs_pkg::ACT_ADD_VERTEX, $urandom_range(255), 0);
            if (i < dfs_pkg::MAX_VERTICES && $urandom_range(2) == 0) begin
                queue_item(dfs_pkg::ACT_ADD_ARC, 0, $urandom_range(31));
            end
        end
        queue_item(dfs_pkg::ACT_START, 0, 0);
        queue_item(dfs_pkg::ACT_CLEAR, 0, 0);
        queue_item(dfs_pkg::ACT_START, 0, 0);
        wait_idle();
        gen_vtx = 0;
        gen_arc = 0;

        // Random graphs under every kind; one phase runs with no gaps at all.
        run_random_phase(dfs_pkg::KIND_UNDIR_NET, RANDOM_ITEMS / 4);
        gap_pct   = 0;
        stall_pct = 0;
        run_random_phase(dfs_pkg::KIND_DIR_NET, RANDOM_ITEMS / 4);
        gap_pct   = 37;
        stall_pct = 37;
        run_random_phase(dfs_pkg::KIND_DIR_GRAPH, RANDOM_ITEMS / 4);
        run_random_phase(dfs_pkg::KIND_UNDIR_GRAPH, RANDOM_ITEMS / 4);

        if (fail_cnt == 0) begin
            $display("dfs_forest_traversal_top: match");
        end else begin
            $display("dfs_forest_traversal_top: mismatch");
        end
        $finish;
    end

endmodule
